/* rtl/deadline_timer_queue_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the deadline timer queue
// Concurrent checks sampled on the rising clock edge, off while reset is low.
// ---------------------------------------------------------------------------
`ifndef DEADLINE_TIMER_QUEUE_ASSERT_SVH
`define DEADLINE_TIMER_QUEUE_ASSERT_SVH

// Same-cycle implication: cons must hold whenever ante holds.
`define DTQ_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication: cons must hold in the cycle after ante.
`define DTQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/dtq_pkg.sv */
// ---------------------------------------------------------------------------
// dtq_pkg
// Field widths, codes and controller/datapath types of the deadline timer queue.
// ---------------------------------------------------------------------------
package dtq_pkg;

    localparam int FUNC_W      = 2;
    localparam int ID_W        = 4;
    localparam int DELAY_W     = 40;
    localparam int TIME_W      = 63;
    // delay_us * 10 fits in 44 bits
    localparam int SPAN_W      = DELAY_W + 4;
    localparam int MAX_RESULTS = 16;
    localparam int FIRE_IDX_W  = $clog2(MAX_RESULTS);
    localparam int FIRE_CNT_W  = FIRE_IDX_W + 1;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_SET    = 2'd0,
        FUNC_STOP   = 2'd1,
        FUNC_REMOVE = 2'd2,
        FUNC_TICK   = 2'd3
    } t_func;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_UPDATE,
        ST_FIRE_SCAN,
        ST_FIRE_COMMIT,
        ST_FINAL_SCAN,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic capture;
        logic update;
        logic scan_clr;
        logic scan_step;
        logic scan_final;
        logic fire_commit;
        logic emit_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic found;
        logic scan_done;
        logic fire_full;
        logic out_free;
        logic emit_last;
    } t_sts;

endpackage

/* rtl/dtq_ifs.sv */
// ---------------------------------------------------------------------------
// dtq channel interfaces
// Request and response channels with valid/ready handshake.
// ---------------------------------------------------------------------------
interface dtq_req_if;
    logic                           valid;
    logic                           ready;
    logic [dtq_pkg::FUNC_W-1:0]     func;
    logic [dtq_pkg::ID_W-1:0]       timer_id;
    logic [dtq_pkg::DELAY_W-1:0]    delay_us;
    logic [dtq_pkg::TIME_W-1:0]     now;

    modport source (output valid, func, timer_id, delay_us, now, input ready);
    modport sink   (input valid, func, timer_id, delay_us, now, output ready);
endinterface

interface dtq_rsp_if;
    logic                           valid;
    logic                           ready;
    logic                           fired;
    logic [dtq_pkg::ID_W-1:0]       fired_id;
    logic                           last;
    logic                           pending;
    logic [dtq_pkg::TIME_W-1:0]     next_expiry;

    modport source (output valid, fired, fired_id, last, pending, next_expiry, input ready);
    modport sink   (input valid, fired, fired_id, last, pending, next_expiry, output ready);
endinterface

/* rtl/dtq_ram.sv */
// ---------------------------------------------------------------------------
// dtq_ram
// Single-port RAM with registered read data.
// ---------------------------------------------------------------------------
module dtq_ram #(
    parameter int WIDTH = 63,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

/* rtl/dtq_ctrl.sv */
// ---------------------------------------------------------------------------
// dtq_ctrl
// Sequencer: update, fire scans, final minimum scan, result emission.
// ---------------------------------------------------------------------------
module dtq_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    input  logic            i_in_tick,
    input  dtq_pkg::t_sts   i_sts,
    output logic            o_in_ready,
    output dtq_pkg::t_cmd   o_cmd
);

    dtq_pkg::t_state r_state;
    dtq_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dtq_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            dtq_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.capture  = 1'b1;
                    o_cmd.scan_clr = 1'b1;
                    n_state = i_in_tick ? dtq_pkg::ST_FIRE_SCAN : dtq_pkg::ST_UPDATE;
                end
            end
            dtq_pkg::ST_UPDATE: begin
                o_cmd.update   = 1'b1;
                o_cmd.scan_clr = 1'b1;
                n_state = dtq_pkg::ST_FINAL_SCAN;
            end
            dtq_pkg::ST_FIRE_SCAN: begin
                if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    n_state = dtq_pkg::ST_FIRE_COMMIT;
                end
            end
            dtq_pkg::ST_FIRE_COMMIT: begin
                o_cmd.scan_clr = 1'b1;
                if (i_sts.found) begin
                    o_cmd.fire_commit = 1'b1;
                    n_state = i_sts.fire_full ? dtq_pkg::ST_FINAL_SCAN
                                              : dtq_pkg::ST_FIRE_SCAN;
                end else begin
                    n_state = dtq_pkg::ST_FINAL_SCAN;
                end
            end
            dtq_pkg::ST_FINAL_SCAN: begin
                o_cmd.scan_final = 1'b1;
                if (!i_sts.scan_done) begin
                    o_cmd.scan_step = 1'b1;
                end else begin
                    o_cmd.emit_start = 1'b1;
                    n_state = dtq_pkg::ST_EMIT;
                end
            end
            dtq_pkg::ST_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    if (i_sts.emit_last) begin
                        n_state = dtq_pkg::ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = dtq_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* rtl/dtq_datapath.sv */
// ---------------------------------------------------------------------------
// dtq_datapath
// Deadline store, armed flags, shared scan compare, fire buffer, output word.
// ---------------------------------------------------------------------------
module dtq_datapath #(
    parameter int NUM_TIMERS = 16
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  dtq_pkg::t_cmd                    i_cmd,
    input  logic [dtq_pkg::FUNC_W-1:0]       i_func,
    input  logic [dtq_pkg::ID_W-1:0]         i_timer_id,
    input  logic [dtq_pkg::DELAY_W-1:0]      i_delay_us,
    input  logic [dtq_pkg::TIME_W-1:0]       i_now,
    input  logic                             i_out_ready,
    output dtq_pkg::t_sts                    o_sts,
    output logic                             o_out_valid,
    output logic                             o_fired,
    output logic [dtq_pkg::ID_W-1:0]         o_fired_id,
    output logic                             o_last,
    output logic                             o_pending,
    output logic [dtq_pkg::TIME_W-1:0]       o_next_expiry
);

    localparam int IW = $clog2(NUM_TIMERS);
    localparam int CW = IW + 1;
    localparam int TW = dtq_pkg::TIME_W;

    // captured request
    dtq_pkg::t_func                 r_func;
    logic [dtq_pkg::ID_W-1:0]       r_id;
    logic [TW-1:0]                  r_now;
    logic [dtq_pkg::SPAN_W-1:0]     r_span;

    // scan state
    logic [CW-1:0]                  r_cnt;
    logic                           r_rd_vld;
    logic [IW-1:0]                  r_rd_idx;
    logic                           r_found;
    logic [TW-1:0]                  r_best_q;
    logic [IW-1:0]                  r_best_idx;
    logic [NUM_TIMERS-1:0]          r_armed;

    // fired indices in order
    logic [dtq_pkg::ID_W-1:0]       r_fire_buf [dtq_pkg::MAX_RESULTS];
    logic [dtq_pkg::FIRE_CNT_W-1:0] r_fire_cnt;
    logic [dtq_pkg::FIRE_IDX_W-1:0] r_emit_idx;

    // output word
    logic                           r_out_valid;
    logic                           r_out_fired;
    logic [dtq_pkg::ID_W-1:0]       r_out_fired_id;
    logic                           r_out_last;
    logic                           r_out_pending;
    logic [TW-1:0]                  r_out_next;

    logic [dtq_pkg::SPAN_W-1:0]     w_delay_ext;
    logic [TW:0]                    w_sum;
    logic [TW-1:0]                  w_deadline;
    logic [IW-1:0]                  w_id_idx;
    logic                           w_id_ok;
    logic                           w_we;
    logic [IW-1:0]                  w_addr;
    logic [TW-1:0]                  w_q;
    logic                           w_cand;
    logic                           w_any_fired;
    logic                           w_emit_last;

    // delay_us * 10 = delay*8 + delay*2
    assign w_delay_ext = dtq_pkg::SPAN_W'(i_delay_us);

    // saturate the deadline at the top of the time range
    assign w_sum      = {1'b0, r_now} + (TW + 1)'(r_span);
    assign w_deadline = w_sum[TW] ? {TW{1'b1}} : w_sum[TW-1:0];

    assign w_id_idx = IW'(r_id);
    assign w_id_ok  = 32'(r_id) < 32'(NUM_TIMERS);
    assign w_we     = i_cmd.update && (r_func == dtq_pkg::FUNC_SET) && w_id_ok;
    assign w_addr   = w_we ? w_id_idx : r_cnt[IW-1:0];

    dtq_ram #(
        .WIDTH (TW),
        .DEPTH (NUM_TIMERS)
    ) u_deadline_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_addr  (w_addr),
        .i_wdata (w_deadline),
        .o_rdata (w_q)
    );

    // one shared compare: fire scans want due entries, final scan wants any armed
    assign w_cand = r_rd_vld && r_armed[r_rd_idx]
                 && (i_cmd.scan_final || (w_q <= r_now))
                 && (!r_found || (w_q < r_best_q));

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= dtq_pkg::t_func'(i_func);
            r_id   <= i_timer_id;
            r_now  <= i_now;
            r_span <= (w_delay_ext << 3) + (w_delay_ext << 1);
        end
        r_rd_idx <= r_cnt[IW-1:0];
        if (w_cand) begin
            r_best_q   <= w_q;
            r_best_idx <= r_rd_idx;
        end
        if (i_cmd.fire_commit) begin
            r_fire_buf[r_fire_cnt[dtq_pkg::FIRE_IDX_W-1:0]] <= dtq_pkg::ID_W'(r_best_idx);
        end
        if (i_cmd.out_load) begin
            r_out_fired    <= w_any_fired;
            r_out_fired_id <= w_any_fired ? r_fire_buf[r_emit_idx] : '0;
            r_out_last     <= w_emit_last;
            r_out_pending  <= r_found;
            r_out_next     <= r_found ? r_best_q : '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt       <= '0;
            r_rd_vld    <= 1'b0;
            r_found     <= 1'b0;
            r_armed     <= '0;
            r_fire_cnt  <= '0;
            r_emit_idx  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_rd_vld <= i_cmd.scan_step;
            if (i_cmd.scan_clr) begin
                r_cnt   <= '0;
                r_found <= 1'b0;
            end else begin
                if (i_cmd.scan_step) begin
                    r_cnt <= r_cnt + CW'(1);
                end
                if (w_cand) begin
                    r_found <= 1'b1;
                end
            end
            if (i_cmd.update && w_id_ok) begin
                r_armed[w_id_idx] <= (r_func == dtq_pkg::FUNC_SET);
            end
            if (i_cmd.fire_commit) begin
                r_armed[r_best_idx] <= 1'b0;
            end
            if (i_cmd.capture) begin
                r_fire_cnt <= '0;
            end else if (i_cmd.fire_commit) begin
                r_fire_cnt <= r_fire_cnt + dtq_pkg::FIRE_CNT_W'(1);
            end
            if (i_cmd.emit_start) begin
                r_emit_idx <= '0;
            end else if (i_cmd.out_load && !w_emit_last) begin
                r_emit_idx <= r_emit_idx + dtq_pkg::FIRE_IDX_W'(1);
            end
            if (i_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign w_any_fired = (r_fire_cnt != '0);
    assign w_emit_last = !w_any_fired
                      || ((dtq_pkg::FIRE_CNT_W'(r_emit_idx) + dtq_pkg::FIRE_CNT_W'(1))
                          == r_fire_cnt);

    assign o_sts.found     = r_found;
    assign o_sts.scan_done = (r_cnt == CW'(NUM_TIMERS));
    assign o_sts.fire_full = (r_fire_cnt == dtq_pkg::FIRE_CNT_W'(dtq_pkg::MAX_RESULTS - 1));
    assign o_sts.out_free  = !r_out_valid || i_out_ready;
    assign o_sts.emit_last = w_emit_last;

    assign o_out_valid   = r_out_valid;
    assign o_fired       = r_out_fired;
    assign o_fired_id    = r_out_fired_id;
    assign o_last        = r_out_last;
    assign o_pending     = r_out_pending;
    assign o_next_expiry = r_out_next;

endmodule

/* rtl/deadline_timer_queue.sv */
// ---------------------------------------------------------------------------
// deadline_timer_queue
// One-shot deadline timers with earliest-first expiry reporting.
// ---------------------------------------------------------------------------
// Request words set, stop or remove a timer, or deliver a tick with the current
// time. Every request gives at least one response word; a tick gives one word
// per expired timer (earliest deadline first, lower index on ties, at most 16),
// with last marking the final one, and all words carry the earliest deadline
// still armed once the request is done. One request is handled at a time. The
// deadlines sit in a single-port RAM that one comparator walks at one entry per
// cycle. Set/stop/remove make one update and one final pass; a tick that fires
// k timers makes one fire pass per fired timer, one more that finds none, and
// the final pass, with no empty fire pass when all 16 fire. A new request is
// taken as soon as the last response word is in the output register, even if it
// is not yet drained.
// ---------------------------------------------------------------------------
`include "deadline_timer_queue_assert.svh"

module deadline_timer_queue #(
    parameter int NUM_TIMERS = 16
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dtq_req_if.sink    i_req,
    dtq_rsp_if.source  o_rsp
);

    dtq_pkg::t_cmd w_cmd;
    dtq_pkg::t_sts w_sts;
    logic          w_in_ready;
    logic          w_in_tick;

    // decode tick directly off the request so the first scan starts at once
    assign w_in_tick   = (i_req.func == dtq_pkg::FUNC_TICK);
    assign i_req.ready = w_in_ready;

    dtq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .i_in_tick  (w_in_tick),
        .i_sts      (w_sts),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    dtq_datapath #(
        .NUM_TIMERS (NUM_TIMERS)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (w_cmd),
        .i_func        (i_req.func),
        .i_timer_id    (i_req.timer_id),
        .i_delay_us    (i_req.delay_us),
        .i_now         (i_req.now),
        .i_out_ready   (o_rsp.ready),
        .o_sts         (w_sts),
        .o_out_valid   (o_rsp.valid),
        .o_fired       (o_rsp.fired),
        .o_fired_id    (o_rsp.fired_id),
        .o_last        (o_rsp.last),
        .o_pending     (o_rsp.pending),
        .o_next_expiry (o_rsp.next_expiry)
    );

    // only a fired word can be followed by another word of the same request
    `DTQ_ASSERT_IMPL(a_nonlast_is_fired, i_clk, i_rst_n, o_rsp.valid && !o_rsp.last, o_rsp.fired, "non-final response word without a fired timer")
    // nothing pending means no deadline to report
    `DTQ_ASSERT_IMPL(a_idle_expiry_zero, i_clk, i_rst_n, o_rsp.valid && !o_rsp.pending, o_rsp.next_expiry == '0, "next_expiry nonzero with nothing pending")
    // a fresh request always runs at least one scan before any response
    `DTQ_ASSERT_NEXT(a_no_load_after_accept, i_clk, i_rst_n, i_req.valid && i_req.ready, !w_cmd.out_load, "response loaded right after a request was taken")
    // drop only a timer that the scan actually selected
    `DTQ_ASSERT_IMPL(a_commit_needs_found, i_clk, i_rst_n, w_cmd.fire_commit, w_sts.found, "fire commit without a selected timer")

endmodule
